// ----- design/plbb_pkg.sv -----
`default_nettype none

package plbb_pkg;

  // Field and table widths
  localparam int FUNC_W     = 3;
  localparam int CHAN_W     = 4;
  localparam int ELAPSED_W  = 16;
  localparam int LEN_W      = 16;
  localparam int HDR_W      = 8;
  localparam int RATE_W     = 32;
  localparam int BACKLOG_W  = 48;

  localparam int NUM_CHANNELS_DEF = 16;

  // Largest framed charge is 8*65535 + 8 + 8*255 + 32, which fits in 20 bits
  localparam int ADD_W = 20;

  // Drain divider: divide by 1000 one 16-bit digit at a time through a scaled
  // reciprocal, ceil(2**36 / 1000), exact for every partial remainder
  localparam int DIVISOR     = 1000;
  localparam int REM_W       = 10;
  localparam int DIGIT_W     = 16;
  localparam int PART_W      = REM_W + DIGIT_W;
  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_W     = 27;
  localparam int DIV_RECIP   = 68719477;
  localparam int PROD_W      = PART_W + RECIP_W;
  localparam int DIV_CYCLES  = 2 * (BACKLOG_W / DIGIT_W);
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK     = 3'd0,
    FN_FRAMED   = 3'd1,
    FN_RAW      = 3'd2,
    FN_SET_RATE = 3'd3,
    FN_QUERY    = 3'd4,
    FN_CLEAR    = 3'd5
  } plbb_func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL,
    ST_DIV,
    ST_QRD,
    ST_EXEC
  } plbb_state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [CHAN_W-1:0]    chan;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [LEN_W-1:0]     len_bytes;
    logic [HDR_W-1:0]     hdr_len;
    logic                 has_seq;
    logic [RATE_W-1:0]    rate_bps;
  } plbb_req_t;

  typedef struct packed {
    logic                 drained;
    logic [RATE_W-1:0]    old_rate;
    logic [BACKLOG_W-1:0] backlog_bits;
  } plbb_rsp_t;

  typedef struct packed {
    logic [RATE_W-1:0]    rate;
    logic [BACKLOG_W-1:0] backlog;
  } plbb_entry_t;

endpackage

`default_nettype wire

// ----- design/per_channel_leaky_bucket_backlog.sv -----
`default_nettype none

// Per-channel leaky-bucket backlog meter. Each channel holds a 48-bit backlog
// in bits and a 32-bit drain rate in bits per second, kept together in one
// entry of a single-port synchronous table (one read or one write per cycle,
// read data registered). Every request yields exactly one response. For
// charge, set-rate, query and clear requests the request transfer issues the
// table read, and the execute step then modifies the entry, writes it back
// and loads the response register. A tick walks every channel: each channel
// costs a read, a 16x32 multiply of elapsed time by rate, a pass through the
// shared divide-by-1000 unit (three 16-bit digits, each a reciprocal multiply
// and a subtraction) and the write-back, after which the addressed channel is
// read and reported as a query. A new request is taken whenever no request is
// in progress, even while the previous response still waits for its transfer;
// a finished request waits only if that response register is still full.
// Reset clears all entries at once through one valid flag per entry, so no
// clearing pass is needed. Requests naming a channel at or beyond NUM_CHANNELS
// report drained with zero rate and backlog and, apart from the drain walk of
// a tick, change nothing.
module per_channel_leaky_bucket_backlog #(
  parameter int NUM_CHANNELS = plbb_pkg::NUM_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  plbb_pkg::plbb_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output plbb_pkg::plbb_rsp_t rsp
);
  import plbb_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  // Channel table and per-entry valid flags
  plbb_entry_t mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] entry_vld;

  plbb_state_t state;
  plbb_state_t state_next;

  plbb_req_t   item;
  logic [IDX_W-1:0] idx;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  plbb_entry_t      rd_data;
  logic             rd_vld;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  plbb_entry_t      wr_data;

  logic [BACKLOG_W-1:0] cur_bl;
  logic [RATE_W-1:0]    cur_rate;

  logic [BACKLOG_W-1:0] walk_bl;
  logic [RATE_W-1:0]    walk_rate;
  logic [BACKLOG_W-1:0] mul_prod;
  logic [BACKLOG_W-1:0] drained_bl;

  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  logic [BACKLOG_W-1:0] div_quot;

  logic                 req_xfer;
  logic                 exec_go;
  logic                 chan_ok;
  logic [ADD_W-1:0]     charge;
  logic [BACKLOG_W:0]   charge_sum;
  plbb_entry_t          exec_entry;
  plbb_rsp_t            exec_rsp;

  assign req_xfer = req_valid && req_ready;
  assign chan_ok  = (32'(item.chan) < NUM_CHANNELS);

  // Hide entries that have not been written since reset
  assign cur_bl   = rd_vld ? rd_data.backlog : '0;
  assign cur_rate = rd_vld ? rd_data.rate    : '0;

  // Drain amount numerator for the walk
  assign mul_prod   = BACKLOG_W'(item.elapsed_ms) * BACKLOG_W'(cur_rate);
  assign drained_bl = (div_quot >= walk_bl) ? '0 : (walk_bl - div_quot);

  plbb_div1000 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Modify the addressed entry
  always_comb begin
    exec_entry.rate    = cur_rate;
    exec_entry.backlog = cur_bl;
    charge             = '0;
    charge_sum         = '0;
    case (item.func)
      FN_FRAMED: begin
        charge = ADD_W'({item.len_bytes, 3'b000}) + ADD_W'(8)
               + ADD_W'({item.hdr_len, 3'b000}) + (item.has_seq ? ADD_W'(32) : '0);
      end
      FN_RAW: begin
        charge = ADD_W'({item.len_bytes, 3'b000});
      end
      default: begin
        charge = '0;
      end
    endcase
    charge_sum = {1'b0, cur_bl} + (BACKLOG_W + 1)'(charge);
    case (item.func)
      FN_FRAMED, FN_RAW: begin
        // saturate at the top of the backlog range
        exec_entry.backlog = charge_sum[BACKLOG_W] ? '1 : charge_sum[BACKLOG_W-1:0];
      end
      FN_SET_RATE: begin
        exec_entry.rate = item.rate_bps;
      end
      FN_CLEAR: begin
        exec_entry.backlog = '0;
      end
      default: begin
        exec_entry.backlog = cur_bl;
      end
    endcase
    if (chan_ok) begin
      exec_rsp.drained      = (exec_entry.backlog == '0);
      exec_rsp.old_rate     = cur_rate;
      exec_rsp.backlog_bits = exec_entry.backlog;
    end else begin
      exec_rsp.drained      = 1'b1;
      exec_rsp.old_rate     = '0;
      exec_rsp.backlog_bits = '0;
    end
  end

  // Sequencer: next state and table controls
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = exec_entry;
    div_start  = 1'b0;
    exec_go    = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        rd_addr   = IDX_W'(req.chan);
        if (req_valid) begin
          if (req.func == FN_TICK) begin
            state_next = ST_RD;
          end else begin
            rd_en      = 1'b1;
            state_next = ST_EXEC;
          end
        end
      end
      ST_RD: begin
        rd_en      = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          wr_en           = 1'b1;
          wr_data.rate    = walk_rate;
          wr_data.backlog = drained_bl;
          state_next      = (idx == LAST_IDX) ? ST_QRD : ST_RD;
        end
      end
      ST_QRD: begin
        rd_en      = 1'b1;
        rd_addr    = IDX_W'(item.chan);
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        wr_addr = IDX_W'(item.chan);
        // hold while the response register is still occupied
        if (!rsp_valid || rsp_ready) begin
          exec_go    = 1'b1;
          wr_en      = chan_ok;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Table storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= entry_vld[rd_addr];
      end
    end
  end

  // Request capture and walk bookkeeping
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      item <= req;
    end
    if (state == ST_MUL) begin
      walk_bl   <= cur_bl;
      walk_rate <= cur_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (req_xfer) begin
      idx <= '0;
    end else if (state == ST_DIV && div_done && idx != LAST_IDX) begin
      idx <= idx + 1'b1;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      rsp <= exec_rsp;
    end
  end

  // A new response appears only out of the execute step
  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_EXEC)
    else $error("response raised outside execute step");

  // The drain divider finishes only while the walk waits for it
  a_div_done_in_walk: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the drain walk");

  // The divider is never restarted while it still works on a channel
  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // A non-tick request goes straight to its read-modify-write step
  a_direct_exec: assert property (@(posedge clk) disable iff (rst)
    req_xfer && req.func != FN_TICK |=> state == ST_EXEC)
    else $error("non-tick request did not go to execute");

  // The table is never written while a request could be taken
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !req_ready)
    else $error("table write while idle");

endmodule

`default_nettype wire

// ----- design/plbb_div1000.sv -----
`default_nettype none

module plbb_div1000 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [plbb_pkg::BACKLOG_W-1:0] dividend,
  output logic                           busy,
  output logic                           done,
  output logic [plbb_pkg::BACKLOG_W-1:0] quotient
);
  import plbb_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(DIV_CYCLES - 1);
  localparam logic [RECIP_W-1:0]   RECIP_K  = RECIP_W'(DIV_RECIP);
  localparam logic [PART_W-1:0]    DIV_K    = PART_W'(DIVISOR);

  logic [BACKLOG_W-1:0] work;
  logic [REM_W-1:0]     rem;
  logic [PART_W-1:0]    part;
  logic [PROD_W-1:0]    prod;
  logic [DIGIT_W-1:0]   qdig;
  logic [PART_W-1:0]    qmul;
  logic [DIV_CNT_W-1:0] cnt;

  // Long division in 16-bit digits, high digit first. For each digit, first
  // multiply the partial remainder by the reciprocal into the product register,
  // then take the quotient digit from the top of the product and the new
  // remainder by one subtraction. Quotient digits shift in at the bottom as
  // dividend digits leave at the top.
  assign part = {rem, work[BACKLOG_W-1 -: DIGIT_W]};
  assign qdig = prod[RECIP_SHIFT +: DIGIT_W];
  assign qmul = PART_W'(qdig) * DIV_K;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_CNT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (busy) begin
      if (!cnt[0]) begin
        prod <= PROD_W'(part) * PROD_W'(RECIP_K);
      end else begin
        work <= {work[BACKLOG_W-DIGIT_W-1:0], qdig};
        rem  <= REM_W'(part - qmul);
      end
    end
  end

  assign quotient = work;

endmodule

`default_nettype wire
